// ----- rtl/box_average_image_downscale_unit_assert.svh -----
// Assertion macros for the RTL, included by box_average_image_downscale_unit.sv.
`ifndef BOX_AVERAGE_IMAGE_DOWNSCALE_UNIT_ASSERT_SVH
`define BOX_AVERAGE_IMAGE_DOWNSCALE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BXAVG_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: lbl");
`define BXAVG_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition: lbl");
`else
`define BXAVG_ASSERT(lbl, clk, rst, prop)
`define BXAVG_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ----- rtl/bxavg_pkg.sv -----
`default_nettype none
package bxavg_pkg;
   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int MAX_SCALE = 16;
   localparam int NUM_CH = 4;
   localparam int CH_W = 8;
   localparam int SUM_W = 16;
   localparam int DIV_W = 16;
   localparam int DIVISOR_W = 9;
   localparam int STEP_W = $clog2(DIV_W);
   localparam int SCALE_W = 5;
   localparam int SIZE_W = 13;
   localparam int BLK_W = $clog2(MAX_SCALE);
   localparam int CMP_W = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_COL,
      ST_MERGE,
      ST_DIV_AVG,
      ST_EMIT
   } bxavg_state_type;

   typedef logic [NUM_CH-1:0][SUM_W-1:0] bxavg_sums_type;

   typedef struct packed {
      logic                 start;
      logic [DIVISOR_W-1:0] divisor;
   } bxavg_div_req_type;

   function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] v);
      logic [SCALE_W-1:0] r;
      r = v;
      if (v == '0) r = SCALE_W'(1);
      else if (v > SCALE_W'(MAX_SCALE)) r = SCALE_W'(MAX_SCALE);
      return r;
   endfunction
endpackage
`default_nettype wire

// ----- rtl/bxavg_line_store.sv -----
`default_nettype none
module bxavg_line_store
   import bxavg_pkg::*;
#(
   parameter int DEPTH = MAX_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire bxavg_sums_type           wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output bxavg_sums_type                rdata
);
   bxavg_sums_type mem [DEPTH];
   bxavg_sums_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ----- rtl/bxavg_divide.sv -----
`default_nettype none
module bxavg_divide
   import bxavg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bxavg_div_req_type div_req,
   input  wire bxavg_sums_type    dividend,
   output logic                   busy,
   output bxavg_sums_type         quotient
);
   bxavg_sums_type                         quo_ff, quo_in;
   logic [NUM_CH-1:0][DIVISOR_W-1:0]       rem_ff, rem_in;
   logic [DIVISOR_W-1:0]                   divisor_ff, divisor_in;
   logic [STEP_W-1:0]                      step_ff, step_in;
   logic                                   busy_ff, busy_in;
   logic [NUM_CH-1:0][DIVISOR_W:0]         rem_sh;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      for (int i = 0; i < NUM_CH; i++) begin
         rem_sh[i] = {rem_ff[i], quo_ff[i][DIV_W-1]};
      end
      if (div_req.start) begin
         quo_in = dividend;
         rem_in = '0;
         divisor_in = div_req.divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < NUM_CH; i++) begin
            if (rem_sh[i] >= {1'b0, divisor_ff}) begin
               rem_in[i] = DIVISOR_W'(rem_sh[i] - {1'b0, divisor_ff});
               quo_in[i] = {quo_ff[i][DIV_W-2:0], 1'b1};
            end else begin
               rem_in[i] = rem_sh[i][DIVISOR_W-1:0];
               quo_in[i] = {quo_ff[i][DIV_W-2:0], 1'b0};
            end
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign busy = busy_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ----- rtl/box_average_image_downscale_unit.sv -----
// Channel | Direction | Payload
// req     | in        | tdata: red, green, blue, alpha (8 bits each)
// rsp     | out       | tdata: avg_red..avg_alpha; tlast: row_end; tuser: image_end
// csr     | in        | index 0..3: scale_x, scale_y, source_width, source_height
//
// A pixel that does not close a horizontal block is accepted without stalling the input.
// A pixel that closes a block runs the 16-step column divider
// and the line store read and write; closing a full block adds the averaging
// divide and output load. Synchronous active-high reset; no line store clearing.
// req_tready drops while a block is being closed or a result waits to be loaded.
`default_nettype none
`include "box_average_image_downscale_unit_assert.svh"
module box_average_image_downscale_unit
   import bxavg_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [31:0]          req_tdata,  // red, green, blue, alpha
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [31:0]               rsp_tdata,  // avg_red, avg_green, avg_blue, avg_alpha
   output logic                      rsp_tlast,  // row_end
   output logic                      rsp_tuser,  // image_end
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SIZE_W-1:0]    csr_wdata
);
   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [SCALE_W-1:0] scale_x_ff, scale_y_ff;
   logic [SIZE_W-1:0]  width_ff, height_ff;

   bxavg_state_type    state_ff, state_in;
   logic [COL_W-1:0]   pc_ff, pc_in, oc_ff, oc_in;
   logic [SIZE_W-1:0]  pr_ff, pr_in;
   logic [BLK_W-1:0]   cib_ff, cib_in, rib_ff, rib_in;
   bxavg_sums_type     brs_ff, brs_in, hsum_ff, hsum_in;
   logic               rib_zero_ff, rib_zero_in, by_end_ff, by_end_in;
   logic               last_col_ff, last_col_in, last_row_ff, last_row_in;
   logic [DIVISOR_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in, rsp_user_ff, rsp_user_in;

   logic [SCALE_W-1:0] sx, sy;
   logic [CMP_W-1:0]   w_eff;
   logic [SIZE_W-1:0]  h_eff;
   logic               accept, last_col, last_row, bx_end, by_end, load_out;
   bxavg_sums_type     brs_sum, merged, rdata, quotient, dividend;
   bxavg_div_req_type  div_req;
   logic               div_busy, line_we, line_re;
   logic [COL_W-1:0]   line_raddr;
   logic [2*SCALE_W-1:0] count_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff <= SCALE_W'(1);
         scale_y_ff <= SCALE_W'(1);
         width_ff <= SIZE_W'(640);
         height_ff <= SIZE_W'(480);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCALE_X: scale_x_ff <= csr_wdata[SCALE_W-1:0];
            CSR_SCALE_Y: scale_y_ff <= csr_wdata[SCALE_W-1:0];
            CSR_SOURCE_WIDTH: width_ff <= csr_wdata;
            CSR_SOURCE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      sx = eff_scale(scale_x_ff);
      sy = eff_scale(scale_y_ff);
      w_eff = (width_ff == '0) ? CMP_W'(1) : CMP_W'(width_ff);
      if (w_eff > CMP_W'(MAX_WIDTH)) w_eff = CMP_W'(MAX_WIDTH);
      h_eff = (height_ff == '0) ? SIZE_W'(1) : height_ff;
      last_col = (CMP_W'(pc_ff) + CMP_W'(1)) >= w_eff;
      last_row = ({1'b0, pr_ff} + (SIZE_W+1)'(1)) >= {1'b0, h_eff};
      bx_end = last_col || ({1'b0, cib_ff} + SCALE_W'(1) >= sx);
      by_end = last_row || ({1'b0, rib_ff} + SCALE_W'(1) >= sy);
      count_full = ({1'b0, cib_ff} + SCALE_W'(1)) * ({1'b0, rib_ff} + SCALE_W'(1));
      for (int c = 0; c < NUM_CH; c++) begin
         brs_sum[c] = brs_ff[c] + SUM_W'(req_tdata[CH_W*c +: CH_W]);
         merged[c] = rib_zero_ff ? hsum_ff[c] : rdata[c] + hsum_ff[c];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      pr_in = pr_ff;
      cib_in = cib_ff;
      rib_in = rib_ff;
      brs_in = brs_ff;
      hsum_in = hsum_ff;
      oc_in = oc_ff;
      rib_zero_in = rib_zero_ff;
      by_end_in = by_end_ff;
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      count_in = count_ff;
      div_req = '0;
      dividend = merged;
      line_we = 1'b0;
      line_re = 1'b0;
      line_raddr = quotient[0][COL_W-1:0];
      load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hsum_in = brs_sum;
               rib_zero_in = (rib_ff == '0);
               by_end_in = by_end;
               last_col_in = last_col;
               last_row_in = last_row;
               count_in = count_full[DIVISOR_W-1:0];
               if (bx_end) begin
                  brs_in = '0;
                  cib_in = '0;
                  div_req.start = 1'b1;
                  div_req.divisor = DIVISOR_W'(sx);
                  dividend = '0;
                  dividend[0] = DIV_W'(pc_ff);
                  state_in = ST_DIV_COL;
               end else begin
                  brs_in = brs_sum;
                  cib_in = cib_ff + BLK_W'(1);
               end
               if (last_col) begin
                  pc_in = '0;
                  if (last_row) begin
                     pr_in = '0;
                     rib_in = '0;
                  end else begin
                     pr_in = pr_ff + SIZE_W'(1);
                     rib_in = ({1'b0, rib_ff} + SCALE_W'(1) >= sy) ? '0 : rib_ff + BLK_W'(1);
                  end
               end else begin
                  pc_in = pc_ff + COL_W'(1);
               end
            end
         end
         ST_DIV_COL: begin
            if (!div_busy) begin
               line_re = 1'b1;
               oc_in = quotient[0][COL_W-1:0];
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            line_we = 1'b1;
            if (by_end_ff) begin
               div_req.start = 1'b1;
               div_req.divisor = count_ff;
               state_in = ST_DIV_AVG;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV_AVG: begin
            if (!div_busy) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      rsp_user_in = rsp_user_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         for (int c = 0; c < NUM_CH; c++) begin
            rsp_data_in[CH_W*c +: CH_W] = (quotient[c][SUM_W-1:CH_W] != '0) ?
               {CH_W{1'b1}} : quotient[c][CH_W-1:0];
         end
         rsp_last_in = last_col_ff;
         rsp_user_in = last_col_ff && last_row_ff;
      end
   end

   always_ff @(posedge clock) begin
      hsum_ff <= hsum_in;
      oc_ff <= oc_in;
      rib_zero_ff <= rib_zero_in;
      by_end_ff <= by_end_in;
      last_col_ff <= last_col_in;
      last_row_ff <= last_row_in;
      count_ff <= count_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff <= '0;
         pr_ff <= '0;
         cib_ff <= '0;
         rib_ff <= '0;
         brs_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         pr_ff <= pr_in;
         cib_ff <= cib_in;
         rib_ff <= rib_in;
         brs_ff <= brs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tuser = rsp_user_ff;

   bxavg_divide u_divide (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .dividend (dividend),
      .busy     (div_busy),
      .quotient (quotient)
   );

   bxavg_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock (clock),
      .we    (line_we),
      .waddr (oc_ff),
      .wdata (merged),
      .re    (line_re),
      .raddr (line_raddr),
      .rdata (rdata)
   );

   `BXAVG_ASSERT(a_we_after_read, clock, reset, line_we |-> $past(line_re))
   `BXAVG_ASSERT(a_out_free, clock, reset, load_out |-> (!rsp_valid_ff || rsp_tready))
   `BXAVG_NEVER(a_start_busy, clock, reset, div_req.start && div_busy)
endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none
module testbench
   import bxavg_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [31:0] data;
      bit          row_end;
      bit          image_end;
   } avg_pixel_type;

   typedef struct {
      bit            is_reg;
      logic [1:0]    idx;
      logic [12:0]   value;
      logic [31:0]   pixel;
      bit            has_avg;
      avg_pixel_type avg;
   } step_type;

   localparam string CH_NAMES [4] = '{"avg_red", "avg_green", "avg_blue", "avg_alpha"};

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [31:0]          req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [31:0]          rsp_tdata;
   logic                 rsp_tlast;
   logic                 rsp_tuser;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0]    csr_wdata;

   avg_pixel_type pending_avgs[$];
   int            error_count;
   int            idle_mode;
   bit            hold_request;
   int            pixels_sent;

   logic [4:0]  scale_x_reg, scale_y_reg;
   logic [12:0] width_reg, height_reg;
   logic [31:0] line_sums[4096][4];
   logic [31:0] row_acc[4];
   int          col_pos, row_pos, col_in_blk, row_in_blk;

   box_average_image_downscale_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp_scale(logic [4:0] v);
      if (v == 0) return 1;
      return (v > MAX_SCALE) ? MAX_SCALE : int'(v);
   endfunction

   function automatic bit average_pixel(logic [31:0] d);
      int sx, sy, w, h, oc, cnt;
      bit last_col, last_row, x_end, y_end, made;
      avg_pixel_type r;
      logic [31:0] q;
      sx = clamp_scale(scale_x_reg);
      sy = clamp_scale(scale_y_reg);
      w = (width_reg == 0) ? 1 : int'(width_reg);
      h = (height_reg == 0) ? 1 : int'(height_reg);
      if (w > 4096) w = 4096;
      made = 0;
      for (int c = 0; c < 4; c++) row_acc[c] += d[8*c +: 8];
      last_col = col_pos + 1 >= w;
      last_row = row_pos + 1 >= h;
      x_end = last_col || col_in_blk + 1 >= sx;
      y_end = last_row || row_in_blk + 1 >= sy;
      if (x_end) begin
         oc = col_pos / sx;
         if (oc >= 4096) oc = 4095;
         for (int c = 0; c < 4; c++) begin
            if (row_in_blk == 0) line_sums[oc][c] = row_acc[c];
            else line_sums[oc][c] += row_acc[c];
            row_acc[c] = 0;
         end
         if (y_end) begin
            cnt = (col_in_blk + 1) * (row_in_blk + 1);
            for (int c = 0; c < 4; c++) begin
               q = line_sums[oc][c] / cnt;
               r.data[8*c +: 8] = (q > 255) ? 8'hff : q[7:0];
            end
            r.row_end = last_col;
            r.image_end = last_col && last_row;
            pending_avgs.push_back(r);
            made = 1;
         end
         col_in_blk = 0;
      end else begin
         col_in_blk++;
      end
      if (last_col) begin
         col_pos = 0;
         if (last_row) begin
            row_pos = 0;
            row_in_blk = 0;
         end else begin
            row_pos++;
            row_in_blk = (row_in_blk + 1 >= sy) ? 0 : row_in_blk + 1;
         end
      end else begin
         col_pos++;
      end
      return made;
   endfunction

   task automatic send_pixel(logic [31:0] d, output bit made);
      int gap;
      gap = 0;
      if (idle_mode == 0 && $urandom_range(0, 99) < 10) gap = $urandom_range(1, 4);
      if (idle_mode == 1 && $urandom_range(0, 99) < 56) gap = $urandom_range(1, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      made = average_pixel(d);
      pixels_sent++;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_avgs.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [12:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SCALE_X:       scale_x_reg = v[4:0];
         CSR_SCALE_Y:       scale_y_reg = v[4:0];
         CSR_SOURCE_WIDTH:  width_reg = v;
         CSR_SOURCE_HEIGHT: height_reg = v;
         default: ;
      endcase
   endtask

   task automatic run_images(int sx, int sy, int w, int h);
      int n;
      bit made;
      drain();
      write_reg(CSR_SCALE_X, 13'(sx));
      write_reg(CSR_SCALE_Y, 13'(sy));
      write_reg(CSR_SOURCE_WIDTH, 13'(w));
      write_reg(CSR_SOURCE_HEIGHT, 13'(h));
      n = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h) * $urandom_range(1, 2);
      repeat (n) send_pixel($urandom(), made);
   endtask

   function automatic int pick_scale();
      int r;
      r = $urandom_range(0, 11);
      if (r == 0) return 0;
      if (r == 1) return $urandom_range(17, 31);
      if (r == 2) return 16;
      return $urandom_range(1, 6);
   endfunction

   always @(posedge clock) begin
      avg_pixel_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_avgs.size() == 0) begin
            $error("unexpected result data %h", rsp_tdata);
            error_count++;
         end else begin
            e = pending_avgs.pop_front();
            for (int c = 0; c < 4; c++) begin
               if (rsp_tdata[8*c +: 8] !== e.data[8*c +: 8]) begin
                  $error("%s expected %h actual %h", CH_NAMES[c], e.data[8*c +: 8],
                         rsp_tdata[8*c +: 8]);
                  error_count++;
               end
            end
            if (rsp_tlast !== e.row_end) begin
               $error("row_end expected %0d actual %0d", e.row_end, rsp_tlast);
               error_count++;
            end
            if (rsp_tuser !== e.image_end) begin
               $error("image_end expected %0d actual %0d", e.image_end, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      int hold_left;
      if (hold_request && hold_left == 0) begin
         hold_left = 400;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (idle_mode == 0) begin
         rsp_tready <= ($urandom_range(0, 99) >= 56);
      end else if (idle_mode == 1) begin
         rsp_tready <= ($urandom_range(0, 99) >= 10);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      step_type steps[$];
      step_type s;
      bit made;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      error_count = 0;
      idle_mode = 0;
      hold_request = 0;
      pixels_sent = 0;
      scale_x_reg = 1;
      scale_y_reg = 1;
      width_reg = 640;
      height_reg = 480;
      row_acc = '{default: 0};
      col_pos = 0;
      row_pos = 0;
      col_in_blk = 0;
      row_in_blk = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      s = '{default: 0};
      s.has_avg = 1;
      s.pixel = 32'h0000_0000; s.avg = '{32'h0000_0000, 0, 0}; steps.push_back(s);
      s.pixel = 32'hffff_ffff; s.avg = '{32'hffff_ffff, 0, 0}; steps.push_back(s);
      s.pixel = 32'hf00f_5aa5; s.avg = '{32'hf00f_5aa5, 0, 0}; steps.push_back(s);
      s = '{default: 0};
      s.is_reg = 1; s.idx = CSR_SOURCE_WIDTH; s.value = 4; steps.push_back(s);
      s = '{default: 0};
      s.has_avg = 1; s.pixel = 32'h0102_0304; s.avg = '{32'h0102_0304, 1, 0};
      steps.push_back(s);
      s = '{default: 0};
      s.is_reg = 1;
      s.idx = CSR_SCALE_X; s.value = 0; steps.push_back(s);
      s.idx = CSR_SCALE_Y; s.value = 31; steps.push_back(s);
      s.idx = CSR_SOURCE_WIDTH; s.value = 0; steps.push_back(s);
      s.idx = CSR_SOURCE_HEIGHT; s.value = 0; steps.push_back(s);
      s = '{default: 0};
      s.has_avg = 1; s.pixel = 32'h1234_5678; s.avg = '{32'h1234_5678, 1, 1};
      steps.push_back(s);
      s = '{default: 0};
      s.is_reg = 1;
      s.idx = CSR_SCALE_X; s.value = 3; steps.push_back(s);
      s.idx = CSR_SCALE_Y; s.value = 2; steps.push_back(s);
      s.idx = CSR_SOURCE_WIDTH; s.value = 4; steps.push_back(s);
      s.idx = CSR_SOURCE_HEIGHT; s.value = 3; steps.push_back(s);
      s = '{default: 0};
      for (int i = 0; i < 12; i++) begin
         s.pixel = (i % 3 == 0) ? 32'hffff_ffff : (i % 3 == 1) ? 32'h0 : $urandom();
         steps.push_back(s);
      end

      foreach (steps[i]) begin
         if (steps[i].is_reg) begin
            drain();
            write_reg(steps[i].idx, steps[i].value);
         end else begin
            send_pixel(steps[i].pixel, made);
            if (steps[i].has_avg && made) begin
               void'(pending_avgs.pop_back());
               pending_avgs.push_back(steps[i].avg);
            end
         end
      end

      // oversized width and tall image, cut short while running
      drain();
      write_reg(CSR_SCALE_X, 16);
      write_reg(CSR_SCALE_Y, 16);
      write_reg(CSR_SOURCE_WIDTH, 13'h1fff);
      write_reg(CSR_SOURCE_HEIGHT, 4096);
      repeat (20) send_pixel($urandom(), made);
      drain();
      write_reg(CSR_SOURCE_WIDTH, 20);
      send_pixel($urandom(), made);
      drain();
      write_reg(CSR_SOURCE_HEIGHT, 2);
      repeat (20) send_pixel($urandom(), made);

      while (pixels_sent < 1450) begin
         if (pixels_sent < 480) begin
            idle_mode = 0;
            run_images(pick_scale(), pick_scale(),
                       ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 24),
                       ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10));
         end else if (pixels_sent < 960) begin
            idle_mode = 1;
            run_images(pick_scale(), pick_scale(), $urandom_range(1, 24),
                       $urandom_range(1, 10));
         end else if (idle_mode != 2) begin
            idle_mode = 2;
            drain();
            hold_request = 1;
            run_images(1, 1, 16, 8);
         end else begin
            run_images(pick_scale(), pick_scale(), $urandom_range(1, 24),
                       $urandom_range(1, 10));
         end
      end

      drain();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire
